[hw/rtl/triangle_contour_slicer_unit_assert.svh]
`ifndef TRIANGLE_CONTOUR_SLICER_UNIT_ASSERT_SVH
`define TRIANGLE_CONTOUR_SLICER_UNIT_ASSERT_SVH

// Assertion macros for the contour slicer.
// The consequent must hold in the same cycle as the antecedent.
`define TCS_ASSERT_SAME(name, clk, dis, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(name, clk, dis, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tcs_pkg.sv]
// ----------------------------------------------------------------------------
// Contour slicer package
// Shared types and constants of the triangle contour slicer.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int COORD_W     = 32;
    localparam int ORD_W       = 20;
    localparam int INTERVAL_W  = 31;
    localparam int VERTEX_W    = 3 * COORD_W + ORD_W;
    localparam int IN_FIELDS_W = 3 * VERTEX_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 5 * COORD_W;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = COORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_FIRST    = 2'd1;
    localparam logic [1:0] REG_TOP      = 2'd2;

    // Triangle edges in the order they are cut.
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_EDGE,
        ST_OPS,
        ST_MUL,
        ST_DIV,
        ST_ROUND,
        ST_DECIDE,
        ST_FLUSH
    } t_state;

endpackage

[hw/rtl/triangle_contour_slicer_unit.sv]
// ----------------------------------------------------------------------------
// Triangle contour slicer
// A triangle is taken while idle. A level outside its height range is
// passed over; inside it, each edge crossed gives an x and a y coordinate,
// both worked out in the shared bit-serial divider. A flush ends the
// triangle; one triangle is worked on at a time.
// Reset (synchronous, active low) idles the sequencer, empties the output
// register and loads interval 1000, first level 0 and top level 0.
// ----------------------------------------------------------------------------
module triangle_contour_slicer_unit #(
    parameter int MAX_LEVELS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // a_x, a_y, a_height, a_order, b_x, b_y, b_height, b_order,
    // c_x, c_y, c_height, c_order, zero fill
    input  logic [tcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // level, start_x, start_y, end_x, end_y
    output logic [tcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // final_res
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CW    = tcs_pkg::COORD_W;
    localparam int KW    = $clog2(MAX_LEVELS + 1);
    localparam int LVL_W = 34 + KW;

    function automatic logic [CW-1:0] mag(input logic [CW:0] v);
        logic [CW:0] t;
        t = v[CW] ? ((CW+1)'(0) - v) : v;
        return t[CW-1:0];
    endfunction

    // Configuration.
    logic [tcs_pkg::INTERVAL_W-1:0] r_interval;
    logic signed [CW-1:0]           r_first;
    logic signed [CW-1:0]           r_top;

    // Triangle.
    logic signed [CW-1:0]            r_x [3];
    logic signed [CW-1:0]            r_y [3];
    logic signed [CW-1:0]            r_h [3];
    logic [tcs_pkg::ORD_W-1:0]       r_ord [3];

    // Sequencer and datapath registers.
    tcs_pkg::t_state r_state, n_state;
    logic signed [LVL_W-1:0] r_lvl, n_lvl;
    logic [KW-1:0]           r_k, n_k;
    logic [1:0]              r_edge, n_edge;
    logic                    r_coord, n_coord;
    logic [1:0]              r_hits, n_hits;
    logic signed [CW-1:0]    r_hx [2];
    logic signed [CW-1:0]    n_hx [2];
    logic signed [CW-1:0]    r_hy [2];
    logic signed [CW-1:0]    n_hy [2];
    logic [CW-1:0]           r_ud, n_ud;
    logic [CW-1:0]           r_un, n_un;
    logic [CW-1:0]           r_us, n_us;
    logic                    r_neg, n_neg;
    logic signed [CW-1:0]    r_pa, n_pa;
    logic [CW-1:0]           r_rem, n_rem;
    logic [CW-1:0]           r_quo, n_quo;
    logic [tcs_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                    r_pend_valid, n_pend_valid;
    logic [tcs_pkg::OUT_TDATA_W-1:0] r_pend, n_pend;
    logic                    r_out_valid, n_out_valid;
    logic [tcs_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;

    // Combinational helpers.
    logic                    in_fire;
    logic                    out_free;
    logic                    cfg_write;
    logic signed [LVL_W-1:0] top_ext;
    logic signed [LVL_W-1:0] lvl_next;
    logic signed [CW-1:0]    lvl32;
    logic                    lvl_done;
    logic                    any_le;
    logic                    any_ge;
    logic                    in_range;
    logic [1:0]              e_i;
    logic [1:0]              j_i;
    logic [1:0]              f_i;
    logic [1:0]              t_i;
    logic signed [CW-1:0]    ha;
    logic signed [CW-1:0]    hb;
    logic                    edge_skip;
    logic signed [CW-1:0]    pa;
    logic signed [CW-1:0]    pb;
    logic [CW:0]             d_p;
    logic [CW:0]             d_n;
    logic [CW:0]             d_s;
    logic [2*CW-1:0]         prod;
    logic [CW:0]             div_sh;
    logic [CW:0]             div_diff;
    logic                    div_ge;
    logic                    rnd;
    logic [CW+1:0]           q_rnd;
    logic [CW+1:0]           pa_ext;
    logic [CW+1:0]           res;
    logic                    seg_ok;
    logic                    out_load;
    logic                    out_last_val;
    logic [tcs_pkg::OUT_TDATA_W-1:0] new_seg;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_axis_tready = (r_state == tcs_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign pready        = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            tcs_pkg::REG_INTERVAL: prdata = {1'b0, r_interval};
            tcs_pkg::REG_FIRST:    prdata = r_first;
            tcs_pkg::REG_TOP:      prdata = r_top;
            default:               prdata = '0;
        endcase
    end

    // Level bookkeeping.
    assign top_ext  = {{(LVL_W-CW){r_top[CW-1]}}, r_top};
    assign lvl_next = r_lvl + {{(LVL_W-tcs_pkg::INTERVAL_W){1'b0}}, r_interval};
    assign lvl32    = r_lvl[CW-1:0];
    assign lvl_done = (r_k == KW'(MAX_LEVELS)) || (r_lvl > top_ext);

    always_comb begin
        any_le = 1'b0;
        any_ge = 1'b0;
        for (int v = 0; v < 3; v++) begin
            if ($signed({{(LVL_W-CW){r_h[v][CW-1]}}, r_h[v]}) <= r_lvl) any_le = 1'b1;
            if ($signed({{(LVL_W-CW){r_h[v][CW-1]}}, r_h[v]}) >= r_lvl) any_ge = 1'b1;
        end
    end
    assign in_range = any_le && any_ge;

    // Edge endpoints.
    always_comb begin
        unique case (r_edge)
            tcs_pkg::EDGE_AB: begin
                e_i = 2'd0;
                j_i = 2'd1;
            end
            tcs_pkg::EDGE_BC: begin
                e_i = 2'd1;
                j_i = 2'd2;
            end
            tcs_pkg::EDGE_CA: begin
                e_i = 2'd2;
                j_i = 2'd0;
            end
            default: begin
                e_i = 2'd0;
                j_i = 2'd1;
            end
        endcase
    end

    assign ha        = r_h[e_i];
    assign hb        = r_h[j_i];
    assign edge_skip = (ha < lvl32 && hb < lvl32) || (ha > lvl32 && hb > lvl32)
                       || (ha == hb);

    // Interpolate from the endpoint with the lower order number; on a tie from
    // the second endpoint of the edge.
    assign f_i = (r_ord[e_i] < r_ord[j_i]) ? e_i : j_i;
    assign t_i = (r_ord[e_i] < r_ord[j_i]) ? j_i : e_i;
    assign pa  = r_coord ? r_y[f_i] : r_x[f_i];
    assign pb  = r_coord ? r_y[t_i] : r_x[t_i];
    assign d_p = {pb[CW-1], pb} - {pa[CW-1], pa};
    assign d_n = {lvl32[CW-1], lvl32} - {r_h[f_i][CW-1], r_h[f_i]};
    assign d_s = {r_h[t_i][CW-1], r_h[t_i]} - {r_h[f_i][CW-1], r_h[f_i]};

    assign prod = r_ud * r_un;

    // The quotient fits in CW bits, so the high product half starts as the
    // partial remainder and stays below the divisor.
    assign div_sh   = {r_rem, r_quo[CW-1]};
    assign div_ge   = div_sh >= {1'b0, r_us};
    assign div_diff = div_sh - {1'b0, r_us};

    // Round half away from zero: bump the magnitude when 2r >= divisor.
    assign rnd    = {r_rem, 1'b0} >= {1'b0, r_us};
    assign q_rnd  = {2'b00, r_quo} + (CW+2)'(rnd);
    assign pa_ext = {{2{r_pa[CW-1]}}, r_pa};
    assign res    = r_neg ? (pa_ext - q_rnd) : (pa_ext + q_rnd);

    assign seg_ok  = (r_hits == 2'd2) && ((r_hx[0] != r_hx[1]) || (r_hy[0] != r_hy[1]));
    assign new_seg = {r_hy[1], r_hx[1], r_hy[0], r_hx[0], lvl32};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = (r_interval == '0) ? tcs_pkg::ST_FLUSH : tcs_pkg::ST_LEVEL;
                end
            end
            tcs_pkg::ST_LEVEL: begin
                if (lvl_done) begin
                    n_state = tcs_pkg::ST_FLUSH;
                end else if (in_range) begin
                    n_state = tcs_pkg::ST_EDGE;
                end
            end
            tcs_pkg::ST_EDGE: begin
                if (!edge_skip) begin
                    n_state = tcs_pkg::ST_OPS;
                end else if (r_edge == tcs_pkg::EDGE_CA) begin
                    n_state = tcs_pkg::ST_DECIDE;
                end
            end
            tcs_pkg::ST_OPS: n_state = tcs_pkg::ST_MUL;
            tcs_pkg::ST_MUL: n_state = tcs_pkg::ST_DIV;
            tcs_pkg::ST_DIV: begin
                if (r_cnt == tcs_pkg::CNT_W'(tcs_pkg::DIV_STEPS - 1)) begin
                    n_state = tcs_pkg::ST_ROUND;
                end
            end
            tcs_pkg::ST_ROUND: begin
                if (!r_coord) begin
                    n_state = tcs_pkg::ST_OPS;
                end else if (r_edge == tcs_pkg::EDGE_CA) begin
                    n_state = tcs_pkg::ST_DECIDE;
                end else begin
                    n_state = tcs_pkg::ST_EDGE;
                end
            end
            tcs_pkg::ST_DECIDE: begin
                if (!(seg_ok && r_pend_valid && !out_free)) begin
                    n_state = tcs_pkg::ST_LEVEL;
                end
            end
            tcs_pkg::ST_FLUSH: begin
                if (!(r_pend_valid && !out_free)) begin
                    n_state = tcs_pkg::ST_IDLE;
                end
            end
            default: n_state = tcs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_lvl        = r_lvl;
        n_k          = r_k;
        n_edge       = r_edge;
        n_coord      = r_coord;
        n_hits       = r_hits;
        n_hx         = r_hx;
        n_hy         = r_hy;
        n_ud         = r_ud;
        n_un         = r_un;
        n_us         = r_us;
        n_neg        = r_neg;
        n_pa         = r_pa;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        out_load     = 1'b0;
        out_last_val = 1'b0;
        unique case (r_state)
            tcs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_lvl        = {{(LVL_W-CW){r_first[CW-1]}}, r_first};
                    n_k          = '0;
                    n_pend_valid = 1'b0;
                end
            end
            tcs_pkg::ST_LEVEL: begin
                if (!lvl_done) begin
                    if (in_range) begin
                        n_edge = tcs_pkg::EDGE_AB;
                        n_hits = '0;
                    end else begin
                        n_lvl = lvl_next;
                        n_k   = r_k + KW'(1);
                    end
                end
            end
            tcs_pkg::ST_EDGE: begin
                if (!edge_skip) begin
                    n_coord = 1'b0;
                end else if (r_edge != tcs_pkg::EDGE_CA) begin
                    n_edge = r_edge + 2'd1;
                end
            end
            tcs_pkg::ST_OPS: begin
                n_ud  = mag(d_p);
                n_un  = mag(d_n);
                n_us  = mag(d_s);
                n_neg = d_p[CW] ^ d_n[CW] ^ d_s[CW];
                n_pa  = pa;
            end
            tcs_pkg::ST_MUL: begin
                n_rem = prod[2*CW-1:CW];
                n_quo = prod[CW-1:0];
                n_cnt = '0;
            end
            tcs_pkg::ST_DIV: begin
                n_rem = div_ge ? div_diff[CW-1:0] : div_sh[CW-1:0];
                n_quo = {r_quo[CW-2:0], div_ge};
                n_cnt = r_cnt + tcs_pkg::CNT_W'(1);
            end
            tcs_pkg::ST_ROUND: begin
                // Only the first two crossings are kept; a third one just counts.
                if (r_hits < 2'd2) begin
                    if (r_coord) begin
                        n_hy[r_hits[0]] = res[CW-1:0];
                    end else begin
                        n_hx[r_hits[0]] = res[CW-1:0];
                    end
                end
                if (!r_coord) begin
                    n_coord = 1'b1;
                end else begin
                    n_coord = 1'b0;
                    n_hits  = r_hits + 2'd1;
                    if (r_edge != tcs_pkg::EDGE_CA) begin
                        n_edge = r_edge + 2'd1;
                    end
                end
            end
            tcs_pkg::ST_DECIDE: begin
                // A segment waits in the pending slot until the next one, or
                // the end of the triangle, tells whether it is the last.
                if (!(seg_ok && r_pend_valid && !out_free)) begin
                    if (seg_ok) begin
                        out_load     = r_pend_valid;
                        n_pend       = new_seg;
                        n_pend_valid = 1'b1;
                    end
                    n_lvl = lvl_next;
                    n_k   = r_k + KW'(1);
                end
            end
            tcs_pkg::ST_FLUSH: begin
                if (r_pend_valid && out_free) begin
                    out_load     = 1'b1;
                    out_last_val = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_out_valid = out_load || (r_out_valid && !m_axis_tready);
        n_out_data  = out_load ? r_pend : r_out_data;
        n_out_last  = out_load ? out_last_val : r_out_last;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcs_pkg::ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_interval   <= tcs_pkg::INTERVAL_RESET;
            r_first      <= '0;
            r_top        <= '0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (cfg_write) begin
                unique case (paddr[3:2])
                    tcs_pkg::REG_INTERVAL: r_interval <= pwdata[tcs_pkg::INTERVAL_W-1:0];
                    tcs_pkg::REG_FIRST:    r_first    <= pwdata;
                    tcs_pkg::REG_TOP:      r_top      <= pwdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int v = 0; v < 3; v++) begin
                r_x[v]   <= s_axis_tdata[v*tcs_pkg::VERTEX_W +: CW];
                r_y[v]   <= s_axis_tdata[v*tcs_pkg::VERTEX_W + CW +: CW];
                r_h[v]   <= s_axis_tdata[v*tcs_pkg::VERTEX_W + 2*CW +: CW];
                r_ord[v] <= s_axis_tdata[v*tcs_pkg::VERTEX_W + 3*CW +: tcs_pkg::ORD_W];
            end
        end
        r_lvl      <= n_lvl;
        r_k        <= n_k;
        r_edge     <= n_edge;
        r_coord    <= n_coord;
        r_hits     <= n_hits;
        r_hx       <= n_hx;
        r_hy       <= n_hy;
        r_ud       <= n_ud;
        r_un       <= n_un;
        r_us       <= n_us;
        r_neg      <= n_neg;
        r_pa       <= n_pa;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_pend     <= n_pend;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

endmodule

[hw/rtl/tcs_checker.sv]
// ----------------------------------------------------------------------------
// Contour slicer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_contour_slicer_unit_assert.svh"

module tcs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            pready
);

    // Taking a triangle makes the block busy: input ready drops after the transfer.
    `TCS_ASSERT_NEXT(a_busy_after_take, i_clk, !i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready straight after a transfer")

    // Reset leaves the block idle with nothing to deliver.
    `TCS_ASSERT_NEXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, s_axis_tready && !m_axis_tvalid, "block not idle after reset")

    // A stalled result stays put.
    `TCS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // The register port never inserts wait states.
    `TCS_ASSERT_SAME(a_pready_high, i_clk, !i_rst_n, 1'b1, pready, "pready low")

endmodule

bind triangle_contour_slicer_unit tcs_checker u_tcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Contour slicer testbench
// Streams triangles into the slicer and checks every contour segment against
// a predictor kept in step with the register settings. The run covers the
// reset settings, extreme levels and coordinates, empty level ranges, the
// level cap and output back-pressure, then several phases of random triangles.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVEL_CAP = 64;
    localparam int IN_W      = tcs_pkg::IN_TDATA_W;
    // Longest time the block may still be busy on a triangle that gives nothing.
    localparam int SETTLE_CYCLES = LEVEL_CAP * (5 + 3 * 70) + 64;
    localparam logic signed [31:0] H_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] H_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [tcs_pkg::ORD_W-1:0] ord;
        logic signed [31:0]        h;
        logic signed [31:0]        y;
        logic signed [31:0]        x;
    } t_vertex;

    typedef t_vertex [2:0] t_triangle;

    typedef struct packed {
        logic               last;
        logic signed [31:0] ey;
        logic signed [31:0] ex;
        logic signed [31:0] sy;
        logic signed [31:0] sx;
        logic signed [31:0] lvl;
    } t_segment;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [tcs_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [tcs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [tcs_pkg::APB_ADDR_W-1:0]   paddr;
    logic [tcs_pkg::APB_DATA_W-1:0]   pwdata;
    logic [tcs_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    // Register settings as the block should hold them.
    logic [tcs_pkg::INTERVAL_W-1:0]   cfg_interval;
    logic signed [31:0]               cfg_first;
    logic signed [31:0]               cfg_top;

    t_segment pending_segments[$];
    int       mismatch_count = 0;
    int       rx_hold_left = 0;
    bit       tx_steady = 1'b0;
    bit       rx_steady = 1'b0;

    triangle_contour_slicer_unit #(
        .MAX_LEVELS(LEVEL_CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #300_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Coordinate of the crossing, measured from the lower-numbered endpoint
    // and rounded half away from zero.
    function automatic longint crossing_coord(input longint pa, input longint pb,
                                              input longint ha, input longint hb,
                                              input longint lvl);
        logic        flip;
        logic [63:0] ud, un, us, prod, q, r;
        if (hb == ha) return pa;
        flip = (pb < pa) ^ (lvl < ha) ^ (hb < ha);
        ud = (pb < pa) ? pa - pb : pb - pa;
        un = (lvl < ha) ? ha - lvl : lvl - ha;
        us = (hb < ha) ? ha - hb : hb - ha;
        prod = ud * un;
        q = prod / us;
        r = prod % us;
        if (r >= us - r) q = q + 1;
        return flip ? pa - longint'(q) : pa + longint'(q);
    endfunction

    function automatic void slice_triangle(input t_triangle facet);
        longint                    px[3], py[3], ph[3];
        logic [tcs_pkg::ORD_W-1:0] ord[3];
        longint                    lo, hi, lvl;
        longint                    cx[3], cy[3];
        int                        hits, f, t, j;
        t_segment                  seg;
        t_segment                  found[$];
        for (int v = 0; v < 3; v++) begin
            px[v] = $signed(facet[v].x);
            py[v] = $signed(facet[v].y);
            ph[v] = $signed(facet[v].h);
            ord[v] = facet[v].ord;
        end
        lo = ph[0];
        hi = ph[0];
        for (int v = 1; v < 3; v++) begin
            if (ph[v] < lo) lo = ph[v];
            if (ph[v] > hi) hi = ph[v];
        end
        if (cfg_interval == 0) return;
        for (int k = 0; k < LEVEL_CAP; k++) begin
            lvl = longint'(cfg_first) + longint'(k) * longint'(cfg_interval);
            if (lvl > longint'(cfg_top)) break;
            if (lvl < lo || lvl > hi) continue;
            hits = 0;
            for (int e = 0; e < 3; e++) begin
                j = (e + 1) % 3;
                if ((ph[e] < lvl && ph[j] < lvl) || (ph[e] > lvl && ph[j] > lvl)) continue;
                if (ph[e] == ph[j]) continue;
                if (ord[e] < ord[j]) begin
                    f = e;
                    t = j;
                end else begin
                    f = j;
                    t = e;
                end
                cx[hits] = crossing_coord(px[f], px[t], ph[f], ph[t], lvl);
                cy[hits] = crossing_coord(py[f], py[t], ph[f], ph[t], lvl);
                hits++;
            end
            if (hits == 2 && (cx[0] != cx[1] || cy[0] != cy[1])) begin
                seg.lvl  = lvl[31:0];
                seg.sx   = cx[0][31:0];
                seg.sy   = cy[0][31:0];
                seg.ex   = cx[1][31:0];
                seg.ey   = cy[1][31:0];
                seg.last = 1'b0;
                found = {found, seg};
            end
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[i]) pending_segments = {pending_segments, found[i]};
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_segment(input t_segment got, input t_segment want);
        if (got.lvl !== want.lvl)
            report_mismatch($sformatf("level got %0d want %0d", got.lvl, want.lvl));
        if (got.sx !== want.sx)
            report_mismatch($sformatf("start_x got %0d want %0d", got.sx, want.sx));
        if (got.sy !== want.sy)
            report_mismatch($sformatf("start_y got %0d want %0d", got.sy, want.sy));
        if (got.ex !== want.ex)
            report_mismatch($sformatf("end_x got %0d want %0d", got.ex, want.ex));
        if (got.ey !== want.ey)
            report_mismatch($sformatf("end_y got %0d want %0d", got.ey, want.ey));
        if (got.last !== want.last)
            report_mismatch($sformatf("final flag got %0b want %0b", got.last, want.last));
    endtask

    always @(posedge i_clk) begin
        t_segment got_seg;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_seg = {m_axis_tlast, m_axis_tdata};
            if (pending_segments.size() == 0)
                report_mismatch($sformatf("unexpected segment at level %0d", got_seg.lvl));
            else
                compare_segment(got_seg, pending_segments.pop_front());
        end
    end

    // Result side: random stalls unless rx_steady is set, plus a hold-off on request while rx_hold_left counts down.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready <= rx_steady || ($urandom_range(99) >= 8);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_vertex vtx(input logic signed [31:0] x, input logic signed [31:0] y,
                                    input logic signed [31:0] h,
                                    input logic [tcs_pkg::ORD_W-1:0] o);
        return '{ord: o, h: h, y: y, x: x};
    endfunction

    function automatic t_triangle make_facet(input t_vertex a, input t_vertex b,
                                             input t_vertex c);
        return {c, b, a};
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(H_MAX)) return H_MAX;
        if (v < longint'(H_MIN)) return H_MIN;
        return v[31:0];
    endfunction

    // Heights are drawn from [h_lo, h_hi]; now and then a vertex sits exactly
    // on a contour level, or two vertices share an order number.
    function automatic t_triangle random_triangle(input longint h_lo, input longint h_hi);
        t_triangle facet;
        longint    span;
        span = h_hi - h_lo + 1;
        for (int v = 0; v < 3; v++) begin
            facet[v].x   = $urandom;
            facet[v].y   = $urandom;
            facet[v].h   = clamp32(h_lo + longint'({$urandom, $urandom} % span));
            facet[v].ord = $urandom_range(20'hFFFFF);
        end
        if ($urandom_range(4) == 0) facet[1].ord = facet[0].ord;
        if ($urandom_range(3) == 0)
            facet[$urandom_range(2)].h = clamp32(longint'(cfg_first)
                + longint'(cfg_interval) * longint'($urandom_range(10)));
        return facet;
    endfunction

    task automatic send_triangle(input t_triangle facet);
        while (!tx_steady && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(facet);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        slice_triangle(facet);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tcs_pkg::REG_INTERVAL: cfg_interval = value[tcs_pkg::INTERVAL_W-1:0];
            tcs_pkg::REG_FIRST:    cfg_first = value;
            tcs_pkg::REG_TOP:      cfg_top = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] step, input logic [31:0] first,
                             input logic [31:0] top);
        apb_write(tcs_pkg::REG_INTERVAL, step);
        apb_write(tcs_pkg::REG_FIRST, first);
        apb_write(tcs_pkg::REG_TOP, top);
    endtask

    // Stops offering triangles, waits for every outstanding segment and then
    // gives the block time to finish a triangle that yields nothing.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_segments.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings leave a single contour at height zero.
    task automatic test_reset_levels();
        send_triangle(make_facet(vtx(H_MIN, H_MIN, H_MIN, 20'h0),
                                 vtx(H_MAX, H_MAX, H_MAX, 20'hFFFFF),
                                 vtx(H_MAX, H_MIN, H_MIN, 20'h12345)));
        send_triangle(make_facet(vtx(H_MAX, H_MIN, H_MAX, 20'hFFFFF),
                                 vtx(H_MIN, H_MAX, H_MIN, 20'h0),
                                 vtx(0, 0, 1, 20'h7)));
        // Entirely flat at the level: every edge is skipped.
        send_triangle(make_facet(vtx(0, 0, 0, 1), vtx(10, 0, 0, 2), vtx(0, 10, 0, 3)));
        // One flat edge lying on the level.
        send_triangle(make_facet(vtx(0, 0, 0, 1), vtx(100, 0, 0, 2), vtx(50, 80, 100, 3)));
        // Level through a vertex gives three crossings.
        send_triangle(make_facet(vtx(0, 0, -100, 1), vtx(100, 0, 0, 2),
                                 vtx(50, 80, 100, 3)));
        // Degenerate triangle: both crossings fall on the same point.
        send_triangle(make_facet(vtx(7, 7, -10, 1), vtx(7, 7, 10, 2), vtx(7, 7, 20, 3)));
        send_triangle(make_facet(vtx(0, 0, -300, 5), vtx(1000, -500, 700, 5),
                                 vtx(-200, 900, 100, 5)));
        // Exact halves, rounded away from zero in both directions.
        send_triangle(make_facet(vtx(0, 0, -1, 1), vtx(1, 0, 1, 2), vtx(0, 5, 1, 3)));
        send_triangle(make_facet(vtx(0, 0, -1, 1), vtx(-1, 0, 1, 2), vtx(0, -5, 1, 3)));
        send_triangle(make_facet(vtx(1, 2, 5, 1), vtx(3, 4, 6, 2), vtx(5, 6, 7, 3)));
        send_triangle(make_facet(vtx(1, 2, -5, 1), vtx(3, 4, -6, 2), vtx(5, 6, -7, 3)));
        send_triangle(make_facet(vtx(H_MIN, H_MAX, -1, 20'hFFFFF),
                                 vtx(H_MAX, H_MIN, 1, 20'hFFFFE),
                                 vtx(0, 0, H_MAX, 20'h0)));
    endtask

    task automatic test_extreme_levels();
        quiesce();
        configure(32'h7FFF_FFFF, H_MIN, H_MAX);
        send_triangle(make_facet(vtx(0, 0, H_MIN, 1), vtx(100, -100, H_MAX, 2),
                                 vtx(-50, 50, 0, 3)));
        send_triangle(make_facet(vtx(H_MIN, H_MIN, H_MAX, 20'hFFFFF),
                                 vtx(H_MAX, H_MAX, H_MIN, 20'h0),
                                 vtx(H_MAX, H_MIN, -1, 3)));
        quiesce();
        configure(1, H_MAX, H_MAX);
        send_triangle(make_facet(vtx(0, 0, H_MAX, 1), vtx(10, 0, H_MIN, 2),
                                 vtx(0, 10, 0, 3)));
        send_triangle(make_facet(vtx(0, 0, H_MAX, 1), vtx(10, 0, H_MAX, 2),
                                 vtx(0, 10, H_MIN, 3)));
    endtask

    task automatic test_empty_level_ranges();
        quiesce();
        configure(0, 0, 1000);
        send_triangle(make_facet(vtx(0, 0, -500, 1), vtx(90, 0, 1500, 2),
                                 vtx(0, 90, 200, 3)));
        send_triangle(make_facet(vtx(H_MIN, 0, H_MIN, 1), vtx(H_MAX, 0, H_MAX, 2),
                                 vtx(0, H_MAX, 0, 3)));
        quiesce();
        // Top level below the first one.
        configure(5, 100, 99);
        send_triangle(make_facet(vtx(0, 0, 0, 1), vtx(90, 0, 200, 2), vtx(0, 90, 100, 3)));
        send_triangle(make_facet(vtx(-9, 4, 50, 3), vtx(8, 1, 150, 2), vtx(3, -6, 99, 1)));
    endtask

    // More levels in range than the block traces.
    task automatic test_level_cap();
        quiesce();
        configure(1, -40, 40);
        send_triangle(make_facet(vtx($urandom, $urandom, -1000, 1),
                                 vtx($urandom, $urandom, 1000, 2),
                                 vtx($urandom, $urandom, 500, 3)));
        send_triangle(make_facet(vtx($urandom, $urandom, 1000, 20'hFFFFF),
                                 vtx($urandom, $urandom, 300, 20'hFFFFF),
                                 vtx($urandom, $urandom, -999, 20'h0)));
        quiesce();
        configure(1, H_MIN, H_MAX);
        send_triangle(make_facet(vtx($urandom, $urandom, H_MIN, 1),
                                 vtx($urandom, $urandom, H_MAX, 2),
                                 vtx($urandom, $urandom, 0, 3)));
    endtask

    // The result side holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        quiesce();
        configure(10, 0, 1000);
        rx_hold_left = 3000;
        for (int i = 0; i < 8; i++) send_triangle(random_triangle(-20, 70));
    endtask

    task automatic test_random_triangles();
        int     kind;
        longint step, first, top, h_lo, h_hi;
        for (int phase = 0; phase < 6; phase++) begin
            quiesce();
            kind = phase % 3;
            tx_steady = (phase == 0);
            rx_steady = (phase == 0);
            case (kind)
                0: begin
                    step  = $urandom_range(50, 1);
                    first = longint'($urandom_range(20000)) - 10000;
                    top   = first + step * longint'($urandom_range(80));
                    h_lo  = first - 2 * step;
                    h_hi  = first + 10 * step;
                end
                1: begin
                    step  = $urandom_range(100000, 100);
                    first = step * (longint'($urandom_range(2000)) - 1000);
                    top   = first + step * longint'($urandom_range(80));
                    h_lo  = first - 2 * step;
                    h_hi  = first + 12 * step;
                end
                default: begin
                    step  = $urandom_range(32'h7FFF_FFFF, 32'h0800_0000);
                    first = longint'($signed($urandom));
                    top   = longint'($signed($urandom));
                    h_lo  = longint'(H_MIN);
                    h_hi  = longint'(H_MAX);
                end
            endcase
            configure(step[31:0], first[31:0], top[31:0]);
            for (int i = 0; i < 47; i++) begin
                if ($urandom_range(9) == 0)
                    send_triangle(random_triangle(longint'(H_MIN), longint'(H_MAX)));
                else
                    send_triangle(random_triangle(h_lo, h_hi));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cfg_interval  = tcs_pkg::INTERVAL_RESET;
        cfg_first     = 0;
        cfg_top       = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_levels();
        test_extreme_levels();
        test_empty_level_ranges();
        test_level_cap();
        test_backpressure();
        test_random_triangles();

        quiesce();
        if (mismatch_count == 0 && pending_segments.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tcs_pkg.sv
hw/rtl/triangle_contour_slicer_unit.sv
hw/rtl/tcs_checker.sv
sim/tb.sv
